### rtl/vmbd_pkg.sv
// Shared types, constants and register indexes for the volume mip downsampler.
package vmbd_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_LOG2_DEF  = 6;
  localparam int MAX_HEIGHT_LOG2_DEF = 6;
  localparam int CHANNEL_BITS_DEF    = 16;

  // Fixed geometry of the block.
  localparam int MAX_DEPTH_LOG2 = 12;
  localparam int NUM_CHANNELS   = 4;
  localparam int CFG_DATA_BITS  = 4;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WIDTH_LOG2    = 2'd0,
    REG_HEIGHT_LOG2   = 2'd1,
    REG_DEPTH_LOG2    = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } cfg_reg_t;

  // Register reset values.
  localparam logic [2:0] WIDTH_LOG2_RST    = 3'd6;
  localparam logic [2:0] HEIGHT_LOG2_RST   = 3'd6;
  localparam logic [3:0] DEPTH_LOG2_RST    = 4'd6;
  localparam logic [2:0] CHANNEL_COUNT_RST = 3'd4;

endpackage

### rtl/volume_mip_box_downsample_core.sv
// Top level of the 2x2x2 box-filter mip downsampler with its partial-sum memory.
// A result is registered in stage 1, then in the output register, after its cube closes.
// Throughput: one source voxel per cycle, set by the read-modify-write of the partial-sum
// memory (read in stage 0, add and write back in stage 1, forwarding the word just written);
// a stalled result stalls the input once the next cube-closing voxel reaches stage 1.
// Reset: synchronous; clears positions, pipeline and output valid, loads register
// defaults. The partial-sum memory is not cleared; each cube's first voxel writes it.
module volume_mip_box_downsample_core #(
  parameter int MAX_WIDTH_LOG2  = vmbd_pkg::MAX_WIDTH_LOG2_DEF,
  parameter int MAX_HEIGHT_LOG2 = vmbd_pkg::MAX_HEIGHT_LOG2_DEF,
  parameter int CHANNEL_BITS    = vmbd_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [CHANNEL_BITS-1:0]      chan_a,
  input  logic signed [CHANNEL_BITS-1:0]      chan_b,
  input  logic signed [CHANNEL_BITS-1:0]      chan_c,
  input  logic signed [CHANNEL_BITS-1:0]      chan_d,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [CHANNEL_BITS-1:0]      avg_a,
  output logic signed [CHANNEL_BITS-1:0]      avg_b,
  output logic signed [CHANNEL_BITS-1:0]      avg_c,
  output logic signed [CHANNEL_BITS-1:0]      avg_d,
  output logic                                level_end,
  input  logic                                cfg_we,
  input  logic [vmbd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [vmbd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int NCH    = vmbd_pkg::NUM_CHANNELS;
  localparam int SW     = CHANNEL_BITS + 3;
  localparam int XW     = MAX_WIDTH_LOG2;
  localparam int YW     = MAX_HEIGHT_LOG2;
  localparam int ZW     = vmbd_pkg::MAX_DEPTH_LOG2;
  localparam int WLW    = $clog2(MAX_WIDTH_LOG2 + 1);
  localparam int HLW    = $clog2(MAX_HEIGHT_LOG2 + 1);
  localparam int DLW    = $clog2(vmbd_pkg::MAX_DEPTH_LOG2 + 1);
  localparam int AW_RAW = MAX_WIDTH_LOG2 + MAX_HEIGHT_LOG2 - 2;
  localparam int AW     = (AW_RAW < 1) ? 1 : AW_RAW;
  localparam int DEPTH  = 1 << AW;

  // Configuration registers and source position.
  logic [2:0]    width_log2, height_log2, channel_count;
  logic [3:0]    depth_log2;
  logic [XW-1:0] x_pos, x_pos_next;
  logic [YW-1:0] y_pos, y_pos_next;
  logic [ZW-1:0] z_pos, z_pos_next;

  // Stage 1 and output registers.
  logic                 s1_valid, s1_first, s1_last, s1_lend;
  logic [AW-1:0]        s1_addr;
  logic signed [SW-1:0] s1_v [NCH];
  logic [NCH*SW-1:0]    rd_data, fwd_data;
  logic                 fwd_hit;
  logic signed [CHANNEL_BITS-1:0] avg_q [NCH];

  // Partial-sum memory, one word holds all channels of one output position.
  logic [NCH*SW-1:0] sum_mem [DEPTH];

  // Stage 0 combinational signals.
  logic [WLW-1:0] wl, owl;
  logic [HLW-1:0] hl;
  logic [DLW-1:0] dl;
  logic [2:0]     nch;
  logic [XW-1:0]  x_mask;
  logic [YW-1:0]  y_mask;
  logic [ZW-1:0]  z_mask;
  logic           x_last, y_last, z_last;
  logic           first, last, lend;
  logic [1:0]     wsh;
  logic [AW-1:0]  pos;
  logic signed [CHANNEL_BITS-1:0] chan_in [NCH];
  logic signed [SW-1:0] v [NCH];
  logic signed [SW-1:0] sum [NCH];
  logic [NCH*SW-1:0] base_word, wr_word;
  logic stall, acc, s1_go;

  assign chan_in[0] = chan_a;
  assign chan_in[1] = chan_b;
  assign chan_in[2] = chan_c;
  assign chan_in[3] = chan_d;

  // Handshake and pipeline advance.
  assign stall    = s1_valid && s1_last && out_valid && !out_ready;
  assign in_ready = !rst && !stall;
  assign acc      = in_valid && in_ready;
  assign s1_go    = s1_valid && !stall;

  // Effective dimensions after saturation, and the position decode.
  always_comb begin
    wl  = (int'(width_log2) > MAX_WIDTH_LOG2) ? WLW'(MAX_WIDTH_LOG2) : WLW'(width_log2);
    hl  = (int'(height_log2) > MAX_HEIGHT_LOG2) ? HLW'(MAX_HEIGHT_LOG2) : HLW'(height_log2);
    dl  = (depth_log2 > 4'(vmbd_pkg::MAX_DEPTH_LOG2)) ?
          DLW'(vmbd_pkg::MAX_DEPTH_LOG2) : DLW'(depth_log2);
    nch = (channel_count == 3'd0) ? 3'd1 :
          ((channel_count > 3'(NCH)) ? 3'(NCH) : channel_count);
    owl = (wl != '0) ? wl - WLW'(1) : '0;

    x_mask = XW'((1 << wl) - 1);
    y_mask = YW'((1 << hl) - 1);
    z_mask = ZW'((1 << dl) - 1);
    x_last = (x_pos == x_mask);
    y_last = (y_pos == y_mask);
    z_last = (z_pos == z_mask);

    first = !x_pos[0] && !y_pos[0] && !z_pos[0];
    last  = ((wl == '0) || x_pos[0]) && ((hl == '0) || y_pos[0]) &&
            ((dl == '0) || z_pos[0]);
    lend  = x_last && y_last && z_last;
    wsh   = 2'(wl == '0) + 2'(hl == '0) + 2'(dl == '0);
    pos   = (AW'(y_pos >> 1) << owl) | AW'(x_pos >> 1);

    for (int c = 0; c < NCH; c++) begin
      v[c] = (3'(c) < nch) ? (SW'(chan_in[c]) <<< wsh) : '0;
    end

    x_pos_next = x_last ? '0 : x_pos + XW'(1);
    y_pos_next = y_pos;
    z_pos_next = z_pos;
    if (x_last) begin
      y_pos_next = y_last ? '0 : y_pos + YW'(1);
      if (y_last) begin
        z_pos_next = z_last ? '0 : z_pos + ZW'(1);
      end
    end
  end

  // Configuration registers and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2    <= vmbd_pkg::WIDTH_LOG2_RST;
      height_log2   <= vmbd_pkg::HEIGHT_LOG2_RST;
      depth_log2    <= vmbd_pkg::DEPTH_LOG2_RST;
      channel_count <= vmbd_pkg::CHANNEL_COUNT_RST;
      x_pos         <= '0;
      y_pos         <= '0;
      z_pos         <= '0;
    end else if (cfg_we) begin
      unique case (vmbd_pkg::cfg_reg_t'(cfg_index))
        vmbd_pkg::REG_WIDTH_LOG2:    width_log2    <= cfg_wdata[2:0];
        vmbd_pkg::REG_HEIGHT_LOG2:   height_log2   <= cfg_wdata[2:0];
        vmbd_pkg::REG_DEPTH_LOG2:    depth_log2    <= cfg_wdata;
        vmbd_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_wdata[2:0];
        default: ;
      endcase
      x_pos <= '0;
      y_pos <= '0;
      z_pos <= '0;
    end else if (acc) begin
      x_pos <= x_pos_next;
      y_pos <= y_pos_next;
      z_pos <= z_pos_next;
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= acc;
    end
  end

  // Stage 1 payload and forwarding of a write to the address being read.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_first <= first;
      s1_last  <= last;
      s1_lend  <= lend;
      s1_addr  <= pos;
      s1_v     <= v;
      fwd_hit  <= s1_go && (s1_addr == pos);
      fwd_data <= wr_word;
    end
  end

  // Memory read port and write port.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data <= sum_mem[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      sum_mem[s1_addr] <= wr_word;
    end
  end

  // Accumulate: the first voxel of a cube overwrites the stale entry.
  always_comb begin
    base_word = fwd_hit ? fwd_data : rd_data;
    for (int c = 0; c < NCH; c++) begin
      sum[c] = s1_first ? s1_v[c] : ($signed(base_word[c*SW +: SW]) + s1_v[c]);
      wr_word[c*SW +: SW] = sum[c];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      for (int c = 0; c < NCH; c++) begin
        avg_q[c] <= sum[c][SW-1:3];
      end
      level_end <= s1_lend;
    end
  end

  assign avg_a = avg_q[0];
  assign avg_b = avg_q[1];
  assign avg_c = avg_q[2];
  assign avg_d = avg_q[3];

endmodule

### rtl/vmbd_checker.sv
// Port-level checker for the volume mip downsampler, bound to the top level.
module vmbd_checker #(
  parameter int CHANNEL_BITS = vmbd_pkg::CHANNEL_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [CHANNEL_BITS-1:0]      avg_a,
  input logic signed [CHANNEL_BITS-1:0]      avg_b,
  input logic signed [CHANNEL_BITS-1:0]      avg_c,
  input logic signed [CHANNEL_BITS-1:0]      avg_d,
  input logic                                level_end,
  input logic                                cfg_we,
  input logic [vmbd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input logic [vmbd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  // Mirror of the channel count register as written through the port.
  logic [2:0] chan_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_cnt <= vmbd_pkg::CHANNEL_COUNT_RST;
    end else if (cfg_we && (cfg_index == vmbd_pkg::REG_CHANNEL_COUNT)) begin
      chan_cnt <= cfg_wdata[2:0];
    end
  end

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(avg_a) && $stable(avg_b) &&
    $stable(avg_c) && $stable(avg_d) && $stable(level_end))
    else $error("stalled result changed");

  // A new result follows an earlier input transaction.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an input transaction");

  // Channels c and d read as zero when the configured count leaves them unused.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (chan_cnt == 3'd1 || chan_cnt == 3'd2 || chan_cnt == 3'd3 ||
    chan_cnt == 3'd0) |-> (avg_d == '0) && (chan_cnt == 3'd3 || avg_c == '0))
    else $error("unused channel not zero");

endmodule

bind volume_mip_box_downsample_core vmbd_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_vmbd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .avg_a(avg_a), .avg_b(avg_b),
  .avg_c(avg_c), .avg_d(avg_d), .level_end(level_end), .cfg_we(cfg_we),
  .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
);

### bench/volume_mip_average_checker.sv
// Checker that predicts each averaged voxel of the mip downsampler and compares it on the output.
module volume_mip_average_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  logic                                     in_ready,
  input  logic signed [vmbd_pkg::CHANNEL_BITS_DEF-1:0] chan_a,
  input  logic signed [vmbd_pkg::CHANNEL_BITS_DEF-1:0] chan_b,
  input  logic signed [vmbd_pkg::CHANNEL_BITS_DEF-1:0] chan_c,
  input  logic signed [vmbd_pkg::CHANNEL_BITS_DEF-1:0] chan_d,
  input  logic                                     out_valid,
  input  logic                                     out_ready,
  input  logic signed [vmbd_pkg::CHANNEL_BITS_DEF-1:0] avg_a,
  input  logic signed [vmbd_pkg::CHANNEL_BITS_DEF-1:0] avg_b,
  input  logic signed [vmbd_pkg::CHANNEL_BITS_DEF-1:0] avg_c,
  input  logic signed [vmbd_pkg::CHANNEL_BITS_DEF-1:0] avg_d,
  input  logic                                     level_end,
  input  logic                                     cfg_we,
  input  logic [vmbd_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [vmbd_pkg::CFG_DATA_BITS-1:0]       cfg_wdata,
  output int                                       fail_count,
  output int                                       pending
);

  localparam int CB          = vmbd_pkg::CHANNEL_BITS_DEF;
  localparam int NCH         = vmbd_pkg::NUM_CHANNELS;
  localparam int SUM_BITS    = CB + 3;
  localparam int MAX_WL      = vmbd_pkg::MAX_WIDTH_LOG2_DEF;
  localparam int MAX_HL      = vmbd_pkg::MAX_HEIGHT_LOG2_DEF;
  localparam int MAX_DL      = vmbd_pkg::MAX_DEPTH_LOG2;
  localparam int SLICE_SITES = 1 << ((MAX_WL - 1) + (MAX_HL - 1));

  typedef struct packed {
    logic signed [CB-1:0] a;
    logic signed [CB-1:0] b;
    logic signed [CB-1:0] c;
    logic signed [CB-1:0] d;
    logic                 level_last;
  } avg_voxel_t;

  // Averages waiting to come out, oldest first.
  avg_voxel_t averages_due [$];
  avg_voxel_t want;

  // Running cube sums for one output slice, and the block's view of the level.
  logic signed [SUM_BITS-1:0] cube_sum [SLICE_SITES][NCH];
  logic [2:0]  width_log2;
  logic [2:0]  height_log2;
  logic [3:0]  depth_log2;
  logic [2:0]  channel_count;
  int unsigned col;
  int unsigned row;
  int unsigned slab;

  // Fold one source voxel into its cube and queue the average when the cube closes.
  task automatic accumulate_voxel(input logic [NCH-1:0][CB-1:0] voxel);
    int unsigned wl, hl, dl, nch, w, h, d, x, y, z, site, shift;
    logic first, closes, level_last;
    logic signed [SUM_BITS-1:0] term;
    logic [NCH-1:0][CB-1:0] mean;
    avg_voxel_t avg;
    wl  = (width_log2 > MAX_WL) ? MAX_WL : width_log2;
    hl  = (height_log2 > MAX_HL) ? MAX_HL : height_log2;
    dl  = (depth_log2 > MAX_DL) ? MAX_DL : depth_log2;
    nch = (channel_count == 0) ? 1 :
          ((channel_count > NCH) ? NCH : channel_count);
    w = 1 << wl;
    h = 1 << hl;
    d = 1 << dl;
    x = col & (w - 1);
    y = row & (h - 1);
    z = slab & (d - 1);
    site  = ((y >> 1) << ((wl > 0) ? wl - 1 : 0)) | (x >> 1);
    // A unit-size axis counts each voxel twice along it.
    shift = (wl == 0) + (hl == 0) + (dl == 0);
    first  = ((x & 1) == 0) && ((y & 1) == 0) && ((z & 1) == 0);
    closes = (wl == 0 || (x & 1) != 0) && (hl == 0 || (y & 1) != 0) &&
             (dl == 0 || (z & 1) != 0);
    level_last = (x == w - 1) && (y == h - 1) && (z == d - 1);

    for (int k = 0; k < NCH; k++) begin
      term = '0;
      if (k < nch) begin
        term = SUM_BITS'($signed(voxel[k]));
        term = term <<< shift;
      end
      if (first) begin
        cube_sum[site][k] = term;
      end else begin
        cube_sum[site][k] = cube_sum[site][k] + term;
      end
      // Floor division by eight is an arithmetic shift.
      mean[k] = CB'(cube_sum[site][k] >>> 3);
    end

    if (closes) begin
      avg.a = mean[0];
      avg.b = mean[1];
      avg.c = mean[2];
      avg.d = mean[3];
      avg.level_last = level_last;
      averages_due.push_back(avg);
    end

    // Raster advance with wrap to a new level.
    x++;
    if (x == w) begin
      x = 0;
      y++;
      if (y == h) begin
        y = 0;
        z++;
        if (z == d) begin
          z = 0;
        end
      end
    end
    col  = x;
    row  = y;
    slab = z;
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
    end
  endtask

  // Track register writes, predict on each input transaction, compare on each output one.
  always @(posedge clk) begin
    if (rst) begin
      width_log2    = vmbd_pkg::WIDTH_LOG2_RST;
      height_log2   = vmbd_pkg::HEIGHT_LOG2_RST;
      depth_log2    = vmbd_pkg::DEPTH_LOG2_RST;
      channel_count = vmbd_pkg::CHANNEL_COUNT_RST;
      col  = 0;
      row  = 0;
      slab = 0;
      fail_count = 0;
      averages_due.delete();
    end else begin
      if (cfg_we) begin
        case (vmbd_pkg::cfg_reg_t'(cfg_index))
          vmbd_pkg::REG_WIDTH_LOG2:    width_log2    = cfg_wdata[2:0];
          vmbd_pkg::REG_HEIGHT_LOG2:   height_log2   = cfg_wdata[2:0];
          vmbd_pkg::REG_DEPTH_LOG2:    depth_log2    = cfg_wdata[3:0];
          vmbd_pkg::REG_CHANNEL_COUNT: channel_count = cfg_wdata[2:0];
          default: ;
        endcase
        // Any write restarts the level.
        col  = 0;
        row  = 0;
        slab = 0;
      end

      if (out_valid && out_ready) begin
        if (averages_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none actual %0d %0d %0d %0d end %0d",
                   $time, avg_a, avg_b, avg_c, avg_d, level_end);
        end else begin
          want = averages_due.pop_front();
          check_field("avg_a", int'($signed(want.a)), int'(avg_a));
          check_field("avg_b", int'($signed(want.b)), int'(avg_b));
          check_field("avg_c", int'($signed(want.c)), int'(avg_c));
          check_field("avg_d", int'($signed(want.d)), int'(avg_d));
          check_field("level_end", int'(want.level_last), int'(level_end));
        end
      end

      if (in_valid && in_ready) begin
        accumulate_voxel({chan_d, chan_c, chan_b, chan_a});
      end
    end
    pending = averages_due.size();
  end

endmodule

### bench/volume_mip_box_downsample_core_tb.sv
// Testbench top for the mip downsampler: clock, reset, voxel stimulus, register phases, verdict.
module volume_mip_box_downsample_core_tb;

  localparam int CB            = vmbd_pkg::CHANNEL_BITS_DEF;
  localparam int TARGET_VOXELS = 1900;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                in_valid  = 1'b0;
  logic                                in_ready;
  logic signed [CB-1:0]                chan_a    = '0;
  logic signed [CB-1:0]                chan_b    = '0;
  logic signed [CB-1:0]                chan_c    = '0;
  logic signed [CB-1:0]                chan_d    = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b1;
  logic signed [CB-1:0]                avg_a;
  logic signed [CB-1:0]                avg_b;
  logic signed [CB-1:0]                avg_c;
  logic signed [CB-1:0]                avg_d;
  logic                                level_end;
  logic                                cfg_we    = 1'b0;
  logic [vmbd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [vmbd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  int fail_count;
  int pending;

  int voxels_sent = 0;
  int burst_left  = 0;
  bit steady_send  = 1'b0;
  bit steady_drain = 1'b0;
  int stall_left   = 0;
  int open_left    = 0;

  // Register values as last written, used only to size each phase.
  int cur_wl = int'(vmbd_pkg::WIDTH_LOG2_RST);
  int cur_hl = int'(vmbd_pkg::HEIGHT_LOG2_RST);
  int cur_dl = int'(vmbd_pkg::DEPTH_LOG2_RST);

  always #10 clk = ~clk;

  volume_mip_box_downsample_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .chan_a    (chan_a),
    .chan_b    (chan_b),
    .chan_c    (chan_c),
    .chan_d    (chan_d),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .avg_a     (avg_a),
    .avg_b     (avg_b),
    .avg_c     (avg_c),
    .avg_d     (avg_d),
    .level_end (level_end),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  volume_mip_average_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .chan_a     (chan_a),
    .chan_b     (chan_b),
    .chan_c     (chan_c),
    .chan_d     (chan_d),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .avg_a      (avg_a),
    .avg_b      (avg_b),
    .avg_c      (avg_c),
    .avg_d      (avg_d),
    .level_end  (level_end),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result receiver: alternates open and stalled stretches unless told to drain steadily.
  always @(negedge clk) begin
    if (stall_left > 0 && !steady_drain) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (open_left > 0 || steady_drain) begin
      out_ready <= 1'b1;
      if (open_left > 0) begin
        open_left = open_left - 1;
      end
    end else begin
      out_ready <= 1'b0;
      stall_left = int'($urandom_range(0, 4));
      open_left  = int'($urandom_range(1, 12));
    end
  end

  // Channel value with a bias toward the extremes of Q8.8.
  function automatic logic [CB-1:0] pick_chan();
    case ($urandom_range(0, 7))
      0: pick_chan = {1'b1, {(CB-1){1'b0}}};
      1: pick_chan = {1'b0, {(CB-1){1'b1}}};
      2: pick_chan = '0;
      3: pick_chan = '1;
      default: pick_chan = CB'($urandom);
    endcase
  endfunction

  // Offer one voxel, with random gaps between bursts, and wait for its transaction.
  task automatic send_voxel(input logic [CB-1:0] a, b, c, d);
    int gap;
    if (burst_left <= 0) begin
      gap = steady_send ? 0 : int'($urandom_range(0, 7));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = int'($urandom_range(1, 24));
    end
    in_valid <= 1'b1;
    chan_a   <= a;
    chan_b   <= b;
    chan_c   <= c;
    chan_d   <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    voxels_sent++;
  endtask

  // Stop sending, let every expected average arrive, then allow for the pipeline.
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input vmbd_pkg::cfg_reg_t idx,
                           input logic [vmbd_pkg::CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // Write the selected registers while the block is idle.
  task automatic configure(input logic [3:0] wl, hl, dl, cc, input logic [3:0] which);
    wait_idle();
    if (which[0]) begin
      write_reg(vmbd_pkg::REG_WIDTH_LOG2, wl);
      cur_wl = int'(wl[2:0]);
    end
    if (which[1]) begin
      write_reg(vmbd_pkg::REG_HEIGHT_LOG2, hl);
      cur_hl = int'(hl[2:0]);
    end
    if (which[2]) begin
      write_reg(vmbd_pkg::REG_DEPTH_LOG2, dl);
      cur_dl = int'(dl);
    end
    if (which[3]) begin
      write_reg(vmbd_pkg::REG_CHANNEL_COUNT, cc);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    int sel;
    int eff;
    int span;
    int count;
    logic [3:0] wl, hl, dl, cc, which;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Single-voxel levels pass each voxel through unchanged.
    configure(4'd0, 4'd0, 4'd0, 4'd4, 4'hF);
    send_voxel(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    send_voxel(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
    send_voxel(16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA);
    send_voxel(16'hFFF8, 16'h0008, 16'h8001, 16'h7FFE);

    // Full cube with a channel count of zero: one channel, and a small negative sum floors.
    configure(4'd1, 4'd1, 4'd1, 4'd0, 4'hF);
    for (int i = 0; i < 8; i++) begin
      send_voxel((i == 0) ? 16'hFFFF : 16'h0000, pick_chan(), pick_chan(), pick_chan());
    end

    // Two-wide row with unit height and depth, channel count above four, extreme sums.
    configure(4'd1, 4'd0, 4'd0, 4'd7, 4'hF);
    repeat (2) send_voxel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    repeat (2) send_voxel(16'h8000, 16'h8000, 16'h8000, 16'h8000);

    // A register write in the middle of a cube drops the partial sums.
    configure(4'd1, 4'd1, 4'd1, 4'd4, 4'hF);
    repeat (3) send_voxel(pick_chan(), pick_chan(), pick_chan(), pick_chan());
    configure(4'd0, 4'd0, 4'd0, 4'd4, 4'b1000);
    repeat (8) send_voxel(16'h8000, 16'h8000, 16'h8000, 16'h8000);

    // Random phases: mostly whole levels of small volumes, some large and cut short.
    phase = 0;
    while (voxels_sent < TARGET_VOXELS) begin
      sel = (phase < 4) ? phase : int'($urandom_range(0, 11));
      case (sel)
        0: begin
          wl = 4'(6 + $urandom_range(0, 1));
          hl = 4'd0;
          dl = 4'($urandom_range(0, 1));
        end
        1: begin
          wl = 4'($urandom_range(0, 1));
          hl = 4'(6 + $urandom_range(0, 1));
          dl = 4'd0;
        end
        2: begin
          wl = 4'd0;
          hl = 4'd0;
          dl = 4'($urandom_range(12, 15));
        end
        3: begin
          wl = 4'd6;
          hl = 4'd6;
          dl = 4'd0;
        end
        default: begin
          wl = 4'($urandom_range(0, 3));
          hl = 4'($urandom_range(0, 3));
          dl = 4'($urandom_range(0, 3));
        end
      endcase
      // The spare top bit of the narrow registers is random.
      wl[3] = 1'($urandom_range(0, 1));
      hl[3] = 1'($urandom_range(0, 1));
      cc    = 4'($urandom_range(0, 7));
      which = (phase < 4 || $urandom_range(0, 3) != 0) ? 4'hF : 4'($urandom_range(0, 15));
      configure(wl, hl, dl, cc, which);

      eff = ((cur_wl > vmbd_pkg::MAX_WIDTH_LOG2_DEF) ? vmbd_pkg::MAX_WIDTH_LOG2_DEF : cur_wl) +
            ((cur_hl > vmbd_pkg::MAX_HEIGHT_LOG2_DEF) ? vmbd_pkg::MAX_HEIGHT_LOG2_DEF : cur_hl) +
            ((cur_dl > vmbd_pkg::MAX_DEPTH_LOG2) ? vmbd_pkg::MAX_DEPTH_LOG2 : cur_dl);
      if (eff <= 6) begin
        span  = 1 << eff;
        count = span * int'($urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0) begin
          count = count + int'($urandom_range(1, span));
        end
      end else begin
        count = int'($urandom_range(40, 200));
      end

      steady_send  = ($urandom_range(0, 4) == 0);
      steady_drain = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < count; i++) begin
        send_voxel(pick_chan(), pick_chan(), pick_chan(), pick_chan());
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/vmbd_pkg.sv
rtl/volume_mip_box_downsample_core.sv
rtl/vmbd_checker.sv
bench/volume_mip_average_checker.sv
bench/volume_mip_box_downsample_core_tb.sv
